// ===== hdl/anhs_pkg.sv =====
package anhs_pkg;

   localparam int BYTE_W = 8;
   localparam int HIST_DEPTH = 4;
   localparam int SPS_BYTES = 3;

   localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
   localparam logic [4:0] NAL_TYPE_SPS = 5'd7;

   // defaults give the codec string avc1.42E01E
   localparam logic [BYTE_W-1:0] DEFAULT_PROFILE = 8'h42;
   localparam logic [BYTE_W-1:0] DEFAULT_CONSTRAINT = 8'hE0;
   localparam logic [BYTE_W-1:0] DEFAULT_LEVEL = 8'h1E;

   localparam logic [2:0] SEEN_MAX = 3'd5;
   localparam logic [2:0] SEEN_SHORT = 3'd3;
   localparam logic [2:0] SEEN_LONG = 3'd4;
   localparam logic [1:0] SPS_LAST_IDX = 2'd2;

   typedef logic [BYTE_W-1:0] byte_type;

   typedef struct packed {
      logic     is_key;
      logic     sps_found;
      byte_type profile_byte;
      byte_type constraint_byte;
      byte_type level_byte;
   } result_type;

endpackage

// ===== hdl/anhs_scan_core.sv =====
module anhs_scan_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  anhs_pkg::byte_type   data_byte,
   input  logic                 last,
   output anhs_pkg::result_type result
);
   import anhs_pkg::*;

   byte_type   hist_ff [HIST_DEPTH];
   byte_type   hist_in [HIST_DEPTH];
   logic [2:0] seen_ff, seen_in;
   logic       key_ff, key_in;
   logic       pend_ff, pend_in;
   logic       long_ff, long_in;
   logic [1:0] taken_ff, taken_in;
   byte_type   cap_ff [SPS_BYTES];
   byte_type   cap_in [SPS_BYTES];
   logic       done_ff, done_in;

   logic       short_sc;
   logic       long_sc;
   logic [4:0] nal_type;

   assign short_sc = (seen_ff >= SEEN_SHORT) && (hist_ff[2] == '0) &&
                     (hist_ff[1] == '0) && (hist_ff[0] == byte_type'(1));
   assign long_sc = short_sc && (seen_ff >= SEEN_LONG) && (hist_ff[3] == '0);
   assign nal_type = data_byte[4:0];

   always_comb begin
      key_in = key_ff;
      pend_in = pend_ff;
      long_in = long_ff;
      taken_in = taken_ff;
      done_in = done_ff;
      for (int i = 0; i < SPS_BYTES; i++) begin
         cap_in[i] = cap_ff[i];
      end
      if (pend_ff) begin
         // collect profile, constraint and level after the sps header
         cap_in[taken_ff] = data_byte;
         taken_in = taken_ff + 2'd1;
         if (taken_ff == SPS_LAST_IDX) begin
            pend_in = 1'b0;
            if (!last || long_ff) begin
               done_in = 1'b1;
            end
         end
      end else if (short_sc) begin
         if (nal_type == NAL_TYPE_IDR && (!last || long_sc)) begin
            key_in = 1'b1;
         end
         if (nal_type == NAL_TYPE_SPS && !done_ff) begin
            pend_in = 1'b1;
            long_in = long_sc;
            taken_in = 2'd0;
         end
      end
      hist_in[0] = data_byte;
      for (int i = 1; i < HIST_DEPTH; i++) begin
         hist_in[i] = hist_ff[i-1];
      end
      seen_in = (seen_ff < SEEN_MAX) ? seen_ff + 3'd1 : seen_ff;
   end

   always_comb begin
      result.is_key = key_in;
      result.sps_found = done_in;
      result.profile_byte = done_in ? cap_in[0] : DEFAULT_PROFILE;
      result.constraint_byte = done_in ? cap_in[1] : DEFAULT_CONSTRAINT;
      result.level_byte = done_in ? cap_in[2] : DEFAULT_LEVEL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         key_ff <= 1'b0;
         pend_ff <= 1'b0;
         long_ff <= 1'b0;
         taken_ff <= '0;
         done_ff <= 1'b0;
      end else if (step_en) begin
         if (last) begin
            // buffer ends, next request starts a fresh scan
            seen_ff <= '0;
            key_ff <= 1'b0;
            pend_ff <= 1'b0;
            long_ff <= 1'b0;
            taken_ff <= '0;
            done_ff <= 1'b0;
         end else begin
            seen_ff <= seen_in;
            key_ff <= key_in;
            pend_ff <= pend_in;
            long_ff <= long_in;
            taken_ff <= taken_in;
            done_ff <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            hist_ff[i] <= hist_in[i];
         end
         for (int i = 0; i < SPS_BYTES; i++) begin
            cap_ff[i] <= cap_in[i];
         end
      end
   end

   a_pend_not_done: assert property (@(posedge clock) disable iff (reset)
      !(pend_ff && done_ff))
      else $error("sps collection pending after capture done");

   a_taken_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (taken_ff != 2'd3))
      else $error("sps byte count overran");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (step_en && last) |=> (seen_ff == '0 && !key_ff && !pend_ff && !done_ff))
      else $error("state not cleared after last byte");

endmodule

// ===== hdl/annexb_nal_header_scanner.sv =====
// a request is registered in s1, then scanned; the result is registered in rsp_ff once
// the request carrying last leaves s1
// throughput: one request per cycle, the scan state updates once per byte
// a stall only arises when a last request meets a result still waiting on the output
// reset: synchronous active high, clears both valid flags and the scan control state
module annexb_nal_header_scanner (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_last,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_is_key,
   output logic                     rsp_sps_found,
   output logic [7:0]               rsp_profile_byte,
   output logic [7:0]               rsp_constraint_byte,
   output logic [7:0]               rsp_level_byte
);
   import anhs_pkg::*;

   logic       s1_valid_ff, s1_valid_in;
   byte_type   s1_data_ff;
   logic       s1_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;
   result_type scan_result;
   logic       out_free;
   logic       s1_advance;
   logic       rsp_load;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_advance;
   assign rsp_load = s1_advance && s1_last_ff;

   anhs_scan_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (s1_advance),
      .data_byte (s1_data_ff),
      .last      (s1_last_ff),
      .result    (scan_result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_data_ff <= req_data_byte;
         s1_last_ff <= req_last;
      end
      if (rsp_load) begin
         rsp_ff <= scan_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_is_key = rsp_ff.is_key;
   assign rsp_sps_found = rsp_ff.sps_found;
   assign rsp_profile_byte = rsp_ff.profile_byte;
   assign rsp_constraint_byte = rsp_ff.constraint_byte;
   assign rsp_level_byte = rsp_ff.level_byte;

   a_stall_only_on_last: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a pending result");

   a_load_gives_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("result lost after last request");

   a_default_bytes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.sps_found) |->
         (rsp_ff.profile_byte == DEFAULT_PROFILE &&
          rsp_ff.constraint_byte == DEFAULT_CONSTRAINT &&
          rsp_ff.level_byte == DEFAULT_LEVEL))
      else $error("default sps bytes wrong");

endmodule
